### hdl/ifp_pkg.sv
`default_nettype none

package ifp_pkg;

    localparam int PAYLOAD_BYTES = 20;
    localparam int IDX_W         = $clog2(PAYLOAD_BYTES);
    localparam int OUT_WORDS     = PAYLOAD_BYTES / 2;
    localparam int WORD_W        = 16;
    localparam int RES_W         = (OUT_WORDS + 1) * WORD_W;

    localparam logic [7:0] HDR_FIRST  = 8'h7F;
    localparam logic [7:0] HDR_SECOND = 8'h80;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_BYTES - 1);

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_HDR2 = 2'd1,
        PH_DATA = 2'd2,
        PH_CSUM = 2'd3
    } phase_t;

    typedef struct packed {
        logic             valid;
        logic [RES_W-1:0] data;
    } res_t;

endpackage

`default_nettype wire

### hdl/imu_frame_parser.sv
// Latency: a result shows on m_tvalid the cycle after its checksum byte is accepted.
// Throughput: one byte per cycle; the only stall is a checksum byte arriving while
//   the previous result is still held in the result register.
// Reset (aresetn low, synchronous): parser back to header hunt, sum, index and
//   good-frame count cleared, result register emptied; payload bytes are not cleared.
`default_nettype none

module imu_frame_parser
    import ifp_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,   // [7:0] rx_byte
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z, [63:48] rate_x,
    // [79:64] rate_y, [95:80] rate_z, [111:96] roll_raw, [127:112] pitch_raw,
    // [143:128] heading_raw, [159:144] temperature_raw, [175:160] good_frames
    output logic [RES_W-1:0]      m_tdata
);

    res_t res;
    logic res_full;

    ifp_collector u_collector (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .res_full (res_full),
        .res      (res)
    );

    ifp_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res      (res),
        .full     (res_full),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

### hdl/ifp_collector.sv
`default_nettype none

module ifp_collector
    import ifp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       res_full,
    output res_t            res
);

    phase_t             phase_reg, phase_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [7:0]         sum_reg, sum_next;
    logic [WORD_W-1:0]  count_reg, count_next;
    logic [7:0]         store_reg [PAYLOAD_BYTES];

    logic accept;
    logic store_en;
    logic frame_start;
    logic emit;

    // hold off a checksum request only while the previous result is untaken
    assign in_ready = !(phase_reg == PH_CSUM && res_full);
    assign accept   = in_valid && in_ready;

    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_HUNT: begin
                if (accept && in_byte == HDR_FIRST) phase_next = PH_HDR2;
            end
            PH_HDR2: begin
                if (accept) begin
                    if (in_byte == HDR_SECOND) phase_next = PH_DATA;
                    else if (in_byte != HDR_FIRST) phase_next = PH_HUNT;
                end
            end
            PH_DATA: begin
                if (accept && idx_reg == LAST_IDX) phase_next = PH_CSUM;
            end
            PH_CSUM: begin
                if (accept) phase_next = PH_HUNT;
            end
            default: phase_next = PH_HUNT;
        endcase
    end

    always_comb begin
        store_en    = 1'b0;
        frame_start = 1'b0;
        emit        = 1'b0;
        case (phase_reg)
            PH_HDR2: frame_start = accept && in_byte == HDR_SECOND;
            PH_DATA: store_en    = accept;
            PH_CSUM: emit        = accept && in_byte == ~sum_reg;
            default: begin
                store_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        if (frame_start) begin
            idx_next = '0;
            sum_next = '0;
        end
        if (store_en) begin
            idx_next = idx_reg + IDX_W'(1);
            sum_next = sum_reg + in_byte;
        end
        if (accept && phase_reg == PH_CSUM) idx_next = '0;
        if (emit) count_next = count_reg + WORD_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            idx_reg   <= '0;
            sum_reg   <= '0;
            count_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_en) store_reg[idx_reg] <= in_byte;
    end

    // pack little-endian words, frame count on top
    always_comb begin
        res.valid = emit;
        res.data  = '0;
        for (int k = 0; k < OUT_WORDS; k++) begin
            res.data[k*WORD_W +: WORD_W] = {store_reg[2*k+1], store_reg[2*k]};
        end
        res.data[OUT_WORDS*WORD_W +: WORD_W] = count_next;
    end

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> idx_reg <= LAST_IDX)
        else $error("payload index out of range");

    a_last_to_csum: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && phase_reg == PH_DATA && idx_reg == LAST_IDX) |=> phase_reg == PH_CSUM)
        else $error("missed checksum phase after last payload byte");

    a_emit_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> (count_reg == WORD_W'($past(count_reg) + WORD_W'(1))) && phase_reg == PH_HUNT)
        else $error("good frame not counted");

    a_no_emit_full: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> !res_full)
        else $error("result produced while result register full");

endmodule

`default_nettype wire

### hdl/ifp_out_reg.sv
`default_nettype none

module ifp_out_reg
    import ifp_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire res_t             res,
    output logic                  full,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [RES_W-1:0]      m_tdata
);

    logic             valid_reg, valid_next;
    logic [RES_W-1:0] data_reg;

    always_comb begin
        valid_next = valid_reg && !m_tready;
        if (res.valid) valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid) data_reg <= res.data;
    end

    assign full     = valid_reg;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

`default_nettype wire

### bench/imu_frame_parser_tb.sv
`default_nettype none

module imu_frame_parser_tb
    import ifp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RX_TARGET       = 1050;
    localparam int DRAIN_CYCLES    = 20;
    localparam int WATCHDOG_CYCLES = 200000;

    // first member lands in the top bits, so accel_x sits at [15:0] as on m_tdata
    typedef struct packed {
        logic        [15:0] good_frames;
        logic signed [15:0] temperature_raw;
        logic signed [15:0] heading_raw;
        logic signed [15:0] pitch_raw;
        logic signed [15:0] roll_raw;
        logic signed [15:0] rate_z;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_x;
        logic signed [15:0] accel_z;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_x;
    } imu_result_t;

    typedef enum int {
        GEN_GOOD,
        GEN_BAD_SUM,
        GEN_BROKEN_HDR,
        GEN_TRUNCATED,
        GEN_NOISE
    } gen_kind_t;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic [7:0]       s_tdata  = 8'h00;
    logic             m_tready = 1'b0;
    logic             s_tready;
    logic             m_tvalid;
    logic [RES_W-1:0] m_tdata;

    imu_frame_parser uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // stimulus and expectations
    logic [7:0]  pending_rx[$];
    imu_result_t expected_frames[$];
    logic [7:0]  frame_payload[PAYLOAD_BYTES];

    // shadow parser state
    phase_t      rx_phase   = PH_HUNT;
    int          pay_idx    = 0;
    logic [7:0]  pay_sum    = 8'h00;
    logic [7:0]  pay_bytes[PAYLOAD_BYTES];
    logic [15:0] good_count = 16'h0000;

    int cycle_count    = 0;
    int bytes_accepted = 0;
    int frames_checked = 0;
    int mismatches     = 0;
    int burst_left     = 1;
    int gap_left       = 0;
    int gen_count[GEN_NOISE+1];

    task automatic track_rx_byte(input logic [7:0] b);
        logic [RES_W-1:0] frame_bits;
        int k;
        case (rx_phase)
            PH_HUNT: begin
                if (b == HDR_FIRST) rx_phase = PH_HDR2;
            end
            PH_HDR2: begin
                if (b == HDR_SECOND) begin
                    rx_phase = PH_DATA;
                    pay_idx  = 0;
                    pay_sum  = 8'h00;
                end else if (b != HDR_FIRST) begin
                    rx_phase = PH_HUNT;
                end
            end
            PH_DATA: begin
                pay_bytes[pay_idx] = b;
                pay_sum = pay_sum + b;
                pay_idx++;
                if (pay_idx >= PAYLOAD_BYTES) rx_phase = PH_CSUM;
            end
            default: begin
                rx_phase = PH_HUNT;
                pay_idx  = 0;
                if (b == ~pay_sum) begin
                    good_count = good_count + 16'd1;
                    for (k = 0; k < OUT_WORDS; k++) begin
                        frame_bits[k*WORD_W +: WORD_W] = {pay_bytes[2*k+1], pay_bytes[2*k]};
                    end
                    frame_bits[OUT_WORDS*WORD_W +: WORD_W] = good_count;
                    expected_frames.push_back(imu_result_t'(frame_bits));
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%04h, got 0x%04h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic set_payload_word(input int k, input logic [15:0] w);
        frame_payload[2*k]   = w[7:0];
        frame_payload[2*k+1] = w[15:8];
    endtask

    // random words, biased toward the extremes and embedded header bytes
    task automatic fill_random_payload();
        int k;
        for (k = 0; k < OUT_WORDS; k++) begin
            case ($urandom_range(0, 11))
                0:       set_payload_word(k, 16'h0000);
                1:       set_payload_word(k, 16'hFFFF);
                2:       set_payload_word(k, 16'h8000);
                3:       set_payload_word(k, 16'h7FFF);
                4:       set_payload_word(k, {HDR_SECOND, HDR_FIRST});
                default: set_payload_word(k, 16'($urandom));
            endcase
        end
    endtask

    task automatic push_frame(input logic [7:0] csum_flip);
        logic [7:0] sum;
        int i;
        sum = 8'h00;
        pending_rx.push_back(HDR_FIRST);
        pending_rx.push_back(HDR_SECOND);
        for (i = 0; i < PAYLOAD_BYTES; i++) begin
            pending_rx.push_back(frame_payload[i]);
            sum = sum + frame_payload[i];
        end
        pending_rx.push_back(~sum ^ csum_flip);
        if (csum_flip == 8'h00) gen_count[GEN_GOOD]++;
        else gen_count[GEN_BAD_SUM]++;
    endtask

    task automatic fill_stimulus();
        int i;
        int n;
        // stray bytes while hunting, then a broken header
        pending_rx.push_back(8'h00);
        pending_rx.push_back(8'hFF);
        pending_rx.push_back(HDR_SECOND);
        pending_rx.push_back(HDR_FIRST);
        pending_rx.push_back(8'h12);
        gen_count[GEN_BROKEN_HDR]++;
        // repeated first header byte ahead of a frame with extreme words
        pending_rx.push_back(HDR_FIRST);
        pending_rx.push_back(HDR_FIRST);
        fill_random_payload();
        set_payload_word(0, 16'h0000);
        set_payload_word(1, 16'hFFFF);
        set_payload_word(2, 16'h8000);
        set_payload_word(3, 16'h7FFF);
        set_payload_word(4, {HDR_SECOND, HDR_FIRST});
        push_frame(8'h00);
        // zero payload with a bad checksum that equals the first header byte;
        // the 0x80 after it must not start a frame
        for (i = 0; i < PAYLOAD_BYTES; i++) frame_payload[i] = 8'h00;
        push_frame(HDR_SECOND);
        pending_rx.push_back(HDR_SECOND);
        for (i = 0; i < PAYLOAD_BYTES; i++) frame_payload[i] = 8'hFF;
        push_frame(8'h00);
        for (i = 0; i < PAYLOAD_BYTES; i++) frame_payload[i] = 8'h00;
        push_frame(8'h00);

        while (pending_rx.size() < RX_TARGET) begin
            n = $urandom_range(0, 99);
            if (n < 65) begin
                repeat ($urandom_range(0, 2)) pending_rx.push_back(8'($urandom));
                if ($urandom_range(0, 3) == 0) pending_rx.push_back(HDR_FIRST);
                fill_random_payload();
                push_frame(8'h00);
            end else if (n < 75) begin
                fill_random_payload();
                push_frame(8'($urandom_range(1, 255)));
            end else if (n < 85) begin
                pending_rx.push_back(HDR_FIRST);
                do n = $urandom_range(0, 255);
                while (n == HDR_FIRST || n == HDR_SECOND);
                pending_rx.push_back(8'(n));
                gen_count[GEN_BROKEN_HDR]++;
            end else if (n < 93) begin
                // cut short: the following bytes get swallowed as payload
                pending_rx.push_back(HDR_FIRST);
                pending_rx.push_back(HDR_SECOND);
                repeat ($urandom_range(1, PAYLOAD_BYTES - 1))
                    pending_rx.push_back(8'($urandom));
                gen_count[GEN_TRUNCATED]++;
            end else begin
                repeat ($urandom_range(1, 6)) pending_rx.push_back(8'($urandom));
                gen_count[GEN_NOISE]++;
            end
        end
    endtask

    // request driver: bursts of random length separated by random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                track_rx_byte(s_tdata);
                bytes_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_rx.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_rx.pop_front();
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor; the receiver cycles through ready, random and periodic stalls
    always @(posedge aclk) begin
        imu_result_t want;
        imu_result_t got;
        cycle_count <= cycle_count + 1;
        case ((cycle_count / 150) % 3)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 2) != 0);
            default: m_tready <= ((cycle_count % 9) >= 4);
        endcase
        if (aresetn && m_tvalid && m_tready) begin
            got = imu_result_t'(m_tdata);
            if (expected_frames.size() == 0) begin
                $error("frame result with none expected: 0x%h", m_tdata);
                mismatches++;
            end else begin
                want = expected_frames.pop_front();
                check_field("accel_x", want.accel_x, got.accel_x);
                check_field("accel_y", want.accel_y, got.accel_y);
                check_field("accel_z", want.accel_z, got.accel_z);
                check_field("rate_x", want.rate_x, got.rate_x);
                check_field("rate_y", want.rate_y, got.rate_y);
                check_field("rate_z", want.rate_z, got.rate_z);
                check_field("roll_raw", want.roll_raw, got.roll_raw);
                check_field("pitch_raw", want.pitch_raw, got.pitch_raw);
                check_field("heading_raw", want.heading_raw, got.heading_raw);
                check_field("temperature_raw", want.temperature_raw, got.temperature_raw);
                check_field("good_frames", want.good_frames, got.good_frames);
                frames_checked++;
            end
        end
    end

    initial begin
        wait (cycle_count >= WATCHDOG_CYCLES);
        $display("simulation failed");
        $finish;
    end

    initial begin
        fill_stimulus();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        while (pending_rx.size() != 0 || s_tvalid || expected_frames.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_frames.size() != 0) begin
            $error("%0d expected frame results never arrived", expected_frames.size());
            mismatches++;
        end
        $display("%0d bytes parsed, %0d frame results checked, %0d mismatches",
                 bytes_accepted, frames_checked, mismatches);
        $display("sent %0d good, %0d bad-checksum, %0d truncated frames, %0d broken headers",
                 gen_count[GEN_GOOD], gen_count[GEN_BAD_SUM], gen_count[GEN_TRUNCATED],
                 gen_count[GEN_BROKEN_HDR]);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

### imu_frame_parser.f
hdl/ifp_pkg.sv
hdl/ifp_collector.sv
hdl/ifp_out_reg.sv
hdl/imu_frame_parser.sv
bench/imu_frame_parser_tb.sv
